@@ rtl/core/i2cm_pkg.sv @@
// Shared types, opcodes and the microcode table of the I2C master bit engine.
package i2cm_pkg;

  localparam int PC_W    = 5;
  localparam int CNT_W   = 3;
  localparam int TICKS_W = 16;

  localparam logic [CNT_W-1:0] BIT_LAST = CNT_W'(7);

  localparam logic [TICKS_W-1:0] TICKS_RESET = TICKS_W'(500);

  // Bus commands.
  localparam logic [2:0] OP_START    = 3'd0;
  localparam logic [2:0] OP_WRITE    = 3'd1;
  localparam logic [2:0] OP_READ_ACK = 3'd2;
  localparam logic [2:0] OP_READ     = 3'd3;
  localparam logic [2:0] OP_SEND_ACK = 3'd4;
  localparam logic [2:0] OP_STOP     = 3'd5;

  // Configuration register indexes.
  localparam logic REG_PHASE_TICKS = 1'b0;

  typedef enum logic [2:0] {
    SDA_HOLD,
    SDA_LO,
    SDA_HI,
    SDA_BIT,
    SDA_NACK
  } sda_sel_e;

  typedef struct packed {
    logic            scl;
    sda_sel_e        sda_sel;
    logic            oe;
    logic            shift;
    logic            rx;
    logic            ack;
    logic            jmp;
    logic            fin;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  // One bus phase handed from the sequencer to the datapath.
  typedef struct packed {
    logic       fire;
    logic       last;
    ctrl_word_t word;
  } step_t;

  localparam logic [PC_W-1:0] PC_START    = PC_W'(0);
  localparam logic [PC_W-1:0] PC_WRITE    = PC_W'(3);
  localparam logic [PC_W-1:0] PC_WR_LOOP  = PC_W'(4);
  localparam logic [PC_W-1:0] PC_READ_ACK = PC_W'(7);
  localparam logic [PC_W-1:0] PC_READ     = PC_W'(9);
  localparam logic [PC_W-1:0] PC_RD_LOOP  = PC_W'(10);
  localparam logic [PC_W-1:0] PC_SEND_ACK = PC_W'(13);
  localparam logic [PC_W-1:0] PC_STOP     = PC_W'(16);

  function automatic logic [PC_W-1:0] entry_pc(input logic [2:0] op);
    logic [PC_W-1:0] pc;
    unique case (op)
      OP_START:    pc = PC_START;
      OP_WRITE:    pc = PC_WRITE;
      OP_READ_ACK: pc = PC_READ_ACK;
      OP_READ:     pc = PC_READ;
      OP_SEND_ACK: pc = PC_SEND_ACK;
      OP_STOP:     pc = PC_STOP;
      default:     pc = PC_START;
    endcase
    return pc;
  endfunction

  function automatic ctrl_word_t mk(input logic scl, input sda_sel_e sel, input logic oe,
                                    input logic shift, input logic rx, input logic ack,
                                    input logic jmp, input logic fin,
                                    input logic [PC_W-1:0] target);
    ctrl_word_t w;
    w.scl     = scl;
    w.sda_sel = sel;
    w.oe      = oe;
    w.shift   = shift;
    w.rx      = rx;
    w.ack     = ack;
    w.jmp     = jmp;
    w.fin     = fin;
    w.target  = target;
    return w;
  endfunction

  // Microcode: one word per bus phase. A word with jmp loops back to target
  // until the bit counter reaches its last bit.
  function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    unique case (pc)
      // start
      PC_W'(0):  w = mk(1'b1, SDA_HI,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
      PC_W'(1):  w = mk(1'b1, SDA_LO,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
      PC_W'(2):  w = mk(1'b0, SDA_LO,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, PC_START);
      // write byte
      PC_W'(3):  w = mk(1'b0, SDA_HOLD, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
      PC_W'(4):  w = mk(1'b0, SDA_BIT,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
      PC_W'(5):  w = mk(1'b1, SDA_BIT,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
      PC_W'(6):  w = mk(1'b0, SDA_BIT,  1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, PC_WR_LOOP);
      // read slave ack
      PC_W'(7):  w = mk(1'b0, SDA_LO,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
      PC_W'(8):  w = mk(1'b1, SDA_LO,   1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, PC_START);
      // read byte
      PC_W'(9):  w = mk(1'b0, SDA_LO,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
      PC_W'(10): w = mk(1'b1, SDA_LO,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
      PC_W'(11): w = mk(1'b1, SDA_LO,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
      PC_W'(12): w = mk(1'b0, SDA_LO,   1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, PC_RD_LOOP);
      // send master ack
      PC_W'(13): w = mk(1'b0, SDA_HOLD, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
      PC_W'(14): w = mk(1'b0, SDA_NACK, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
      PC_W'(15): w = mk(1'b1, SDA_NACK, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, PC_START);
      // stop
      PC_W'(16): w = mk(1'b0, SDA_LO,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
      PC_W'(17): w = mk(1'b1, SDA_LO,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
      PC_W'(18): w = mk(1'b1, SDA_HI,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, PC_START);
      default:   w = mk(1'b1, SDA_HOLD, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, PC_START);
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/i2c_master_bit_engine.sv @@
// Top level of the I2C master bit engine: configuration port and core wiring.
//
// Each accepted command (start, write byte, read ack, read byte, send ack,
// stop) produces its run of bus phases as output beats, one per phase: 3
// for start, send ack and stop, 2 for read ack, 25 for write and read byte.
// Each phase runs the phase timer countdown, whose end loads the output
// register, then presents the beat (a phase_ticks of zero counts as one
// tick) and holds it while it is stalled. The next command is taken only
// after the last beat of the current one has been delivered; unused op
// codes are accepted and produce no beats. phase_ticks sits at byte
// address 0 of the APB port and resets to 500.
module i2c_master_bit_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [7:0]  tx_byte_i,
  input  logic        nack_i,
  input  logic [7:0]  sda_samples_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        scl_o,
  output logic        sda_out_o,
  output logic        sda_oe_o,
  output logic [7:0]  rx_byte_o,
  output logic        acked_o,
  output logic        last_o
);
  import i2cm_pkg::*;

  logic [TICKS_W-1:0] phase_ticks_q;
  logic               reg_sel;
  logic               load;
  step_t              step;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[1:0] == 2'b00) && (paddr[2] == REG_PHASE_TICKS);
  assign prdata  = reg_sel ? {{(32-TICKS_W){1'b0}}, phase_ticks_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= TICKS_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      phase_ticks_q <= pwdata[TICKS_W-1:0];
    end
  end

  i2cm_sequencer u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .op_i          (op_i),
    .phase_ticks_i (phase_ticks_q),
    .out_stall_i   (out_stall_i),
    .in_stall_o    (in_stall_o),
    .load_o        (load),
    .out_valid_o   (out_valid_o),
    .step_o        (step)
  );

  i2cm_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .tx_byte_i     (tx_byte_i),
    .nack_i        (nack_i),
    .sda_samples_i (sda_samples_i),
    .step_i        (step),
    .scl_o         (scl_o),
    .sda_out_o     (sda_out_o),
    .sda_oe_o      (sda_oe_o),
    .rx_byte_o     (rx_byte_o),
    .acked_o       (acked_o),
    .last_o        (last_o)
  );

endmodule

@@ rtl/core/i2cm_sequencer.sv @@
// Microcode sequencer: step counter, bit loop counter and phase timer.
module i2cm_sequencer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [2:0]                   op_i,
  input  logic [i2cm_pkg::TICKS_W-1:0] phase_ticks_i,
  input  logic                         out_stall_i,
  output logic                         in_stall_o,
  output logic                         load_o,
  output logic                         out_valid_o,
  output i2cm_pkg::step_t              step_o
);
  import i2cm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [PC_W-1:0]    pc_q, pc_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [TICKS_W-1:0] timer_q, timer_d;
  logic               done_q, done_d;
  logic               accept;
  logic               jump;
  logic               fire;
  ctrl_word_t         word;

  assign word        = ucode(pc_q);
  assign jump        = word.jmp && (cnt_q != BIT_LAST);
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign load_o      = accept && (op_i <= OP_STOP);
  // A phase_ticks of zero behaves as a phase_ticks of one.
  assign fire        = (state_q == S_RUN) && (timer_q <= TICKS_W'(1));
  assign out_valid_o = (state_q == S_OUT);

  assign step_o.fire = fire;
  assign step_o.last = word.fin && !jump;
  assign step_o.word = word;

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    cnt_d   = cnt_q;
    timer_d = timer_q;
    done_d  = done_q;
    unique case (state_q)
      S_IDLE: begin
        if (load_o) begin
          pc_d    = entry_pc(op_i);
          cnt_d   = '0;
          timer_d = phase_ticks_i;
          done_d  = 1'b0;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (fire) begin
          if (jump) begin
            pc_d  = word.target;
            cnt_d = cnt_q + CNT_W'(1);
          end else begin
            pc_d  = pc_q + PC_W'(1);
          end
          done_d  = word.fin && !jump;
          state_d = S_OUT;
        end else begin
          timer_d = timer_q - TICKS_W'(1);
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          timer_d = phase_ticks_i;
          state_d = done_q ? S_IDLE : S_RUN;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      cnt_q   <= '0;
      timer_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      cnt_q   <= cnt_d;
      timer_q <= timer_d;
      done_q  <= done_d;
    end
  end

endmodule

@@ rtl/core/i2cm_datapath.sv @@
// Datapath: command operands, SDA output latch and the result beat register.
module i2cm_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  logic [7:0]      tx_byte_i,
  input  logic            nack_i,
  input  logic [7:0]      sda_samples_i,
  input  i2cm_pkg::step_t step_i,
  output logic            scl_o,
  output logic            sda_out_o,
  output logic            sda_oe_o,
  output logic [7:0]      rx_byte_o,
  output logic            acked_o,
  output logic            last_o
);
  import i2cm_pkg::*;

  logic [7:0] shift_q;
  logic       nack_q;
  logic [7:0] samples_q;
  logic       sda_level_q;
  logic       sda_val;

  always_comb begin
    unique case (step_i.word.sda_sel)
      SDA_HOLD: sda_val = sda_level_q;
      SDA_LO:   sda_val = 1'b0;
      SDA_HI:   sda_val = 1'b1;
      SDA_BIT:  sda_val = shift_q[7];
      SDA_NACK: sda_val = nack_q;
      default:  sda_val = sda_level_q;
    endcase
  end

  // The SDA latch keeps its level while the line is released.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sda_level_q <= 1'b1;
    end else if (step_i.fire && step_i.word.oe) begin
      sda_level_q <= sda_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      shift_q   <= tx_byte_i;
      nack_q    <= nack_i;
      samples_q <= sda_samples_i;
    end else if (step_i.fire && step_i.word.shift) begin
      shift_q <= {shift_q[6:0], 1'b0};
    end
  end

  // The read byte is the sample word itself once all eight bits are in.
  always_ff @(posedge clk_i) begin
    if (step_i.fire) begin
      scl_o     <= step_i.word.scl;
      sda_oe_o  <= step_i.word.oe;
      sda_out_o <= step_i.word.oe && sda_val;
      rx_byte_o <= (step_i.word.rx && step_i.last) ? samples_q : 8'h00;
      acked_o   <= step_i.word.ack && !samples_q[7];
      last_o    <= step_i.last;
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// Testbench for the I2C master bit engine: bus commands in, phase beats checked one by one.
module tb;
  import i2cm_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int REG_SPARE = 1;
  localparam logic [2:0] ADDR_TICKS = 3'(4 * REG_PHASE_TICKS);
  localparam logic [2:0] ADDR_SPARE = 3'(4 * REG_SPARE);
  localparam int WATCHDOG_LIMIT = 400000;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_oe;
    logic [7:0] rx_byte;
    logic       acked;
    logic       last;
  } bus_phase_t;

  class phase_scoreboard;
    bus_phase_t phase_q[$];
    logic       sda_latch;
    int         errors;

    function new();
      sda_latch = 1'b1;
      errors = 0;
    endfunction

    // The SDA output latch keeps its level while the line is released.
    function void push_phase(logic scl, logic sda, logic oe, logic [7:0] rx, logic ack);
      bus_phase_t p;
      if (oe) sda_latch = sda;
      p.scl = scl;
      p.sda_out = oe ? sda_latch : 1'b0;
      p.sda_oe = oe;
      p.rx_byte = rx;
      p.acked = ack;
      p.last = 1'b0;
      phase_q.push_back(p);
    endfunction

    function void add_command(logic [2:0] op, logic [7:0] tx, logic nk, logic [7:0] samples);
      int first;
      first = phase_q.size();
      case (op)
        OP_START: begin
          push_phase(1'b1, 1'b1, 1'b1, 8'h00, 1'b0);
          push_phase(1'b1, 1'b0, 1'b1, 8'h00, 1'b0);
          push_phase(1'b0, 1'b0, 1'b1, 8'h00, 1'b0);
        end
        OP_WRITE: begin
          push_phase(1'b0, sda_latch, 1'b1, 8'h00, 1'b0);
          for (int i = 7; i >= 0; i--) begin
            push_phase(1'b0, tx[i], 1'b1, 8'h00, 1'b0);
            push_phase(1'b1, tx[i], 1'b1, 8'h00, 1'b0);
            push_phase(1'b0, tx[i], 1'b1, 8'h00, 1'b0);
          end
        end
        OP_READ_ACK: begin
          push_phase(1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
          push_phase(1'b1, 1'b0, 1'b0, 8'h00, ~samples[7]);
        end
        OP_READ: begin
          push_phase(1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
          for (int i = 7; i >= 0; i--) begin
            push_phase(1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
            push_phase(1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
            push_phase(1'b0, 1'b0, 1'b0, (i == 0) ? samples : 8'h00, 1'b0);
          end
        end
        OP_SEND_ACK: begin
          push_phase(1'b0, sda_latch, 1'b1, 8'h00, 1'b0);
          push_phase(1'b0, nk, 1'b1, 8'h00, 1'b0);
          push_phase(1'b1, nk, 1'b1, 8'h00, 1'b0);
        end
        OP_STOP: begin
          push_phase(1'b0, 1'b0, 1'b1, 8'h00, 1'b0);
          push_phase(1'b1, 1'b0, 1'b1, 8'h00, 1'b0);
          push_phase(1'b1, 1'b1, 1'b1, 8'h00, 1'b0);
        end
        default: ;
      endcase
      if (phase_q.size() > first) phase_q[phase_q.size() - 1].last = 1'b1;
    endfunction

    function void report(string name, logic [7:0] want, logic [7:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    endfunction

    function void check_phase(bus_phase_t got);
      bus_phase_t want;
      if (phase_q.size() == 0) begin
        errors++;
        $display("%0t: phase beat with none expected, expected nothing, got %0h",
                 $time, got);
        return;
      end
      want = phase_q.pop_front();
      if (got.scl !== want.scl) report("scl", want.scl, got.scl);
      if (got.sda_out !== want.sda_out) report("sda_out", want.sda_out, got.sda_out);
      if (got.sda_oe !== want.sda_oe) report("sda_oe", want.sda_oe, got.sda_oe);
      if (got.rx_byte !== want.rx_byte) report("rx_byte", want.rx_byte, got.rx_byte);
      if (got.acked !== want.acked) report("acked", want.acked, got.acked);
      if (got.last !== want.last) report("last", want.last, got.last);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  op_i = OP_START;
  logic [7:0]  tx_byte_i = '0;
  logic        nack_i = 1'b0;
  logic [7:0]  sda_samples_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        scl_o;
  logic        sda_out_o;
  logic        sda_oe_o;
  logic [7:0]  rx_byte_o;
  logic        acked_o;
  logic        last_o;

  phase_scoreboard sb = new();
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          cmds_sent = 0;
  int          quiet_cycles = 0;
  logic [15:0] ticks_shadow = TICKS_RESET;

  i2c_master_bit_engine i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .tx_byte_i     (tx_byte_i),
    .nack_i        (nack_i),
    .sda_samples_i (sda_samples_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .scl_o         (scl_o),
    .sda_out_o     (sda_out_o),
    .sda_oe_o      (sda_oe_o),
    .rx_byte_o     (rx_byte_o),
    .acked_o       (acked_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Result side: check accepted beats, stall at random, and watch for a hang.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_phase(bus_phase_t'{scl_o, sda_out_o, sda_oe_o, rx_byte_o, acked_o, last_o});
    out_stall_i <= ($urandom_range(99) < stall_pct);
    if (rst_ni && ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_ticks();
    logic [31:0] rd;
    apb_xfer(1'b0, ADDR_TICKS, 32'h0, rd);
    if (rd !== {16'h0, ticks_shadow}) begin
      sb.errors++;
      $display("%0t: phase_ticks readback mismatch, expected %0h, got %0h",
               $time, ticks_shadow, rd);
    end
  endtask

  // Only the low 16 bits of the bus word land in the register.
  task automatic set_ticks(input logic [31:0] value);
    logic [31:0] rd;
    apb_xfer(1'b1, ADDR_TICKS, value, rd);
    ticks_shadow = value[15:0];
    check_ticks();
  endtask

  task automatic issue_cmd(input logic [2:0] op, input logic [7:0] tx, input logic nk,
                           input logic [7:0] samples);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    tx_byte_i <= tx;
    nack_i <= nk;
    sda_samples_i <= samples;
    do @(posedge clk_i); while (in_stall_o);
    sb.add_command(op, tx, nk, samples);
    if (op != OP_SPARE_LO && op != OP_SPARE_HI) cmds_sent++;
  endtask

  task automatic issue_rand(input logic [2:0] op);
    issue_cmd(op, 8'($urandom), 1'($urandom_range(1)), 8'($urandom));
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (sb.phase_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic reconfigure(input logic [31:0] ticks, input int idle, input int stall);
    wait_drain();
    repeat (16) @(posedge clk_i);
    set_ticks(ticks);
    idle_pct = idle;
    stall_pct = stall;
  endtask

  // A complete addressed transfer: start, address, then data bytes in one direction, chosen at random.
  task automatic bus_transfer();
    int  n_bytes;
    logic rd_dir;
    n_bytes = $urandom_range(1, 3);
    rd_dir = 1'($urandom_range(1));
    issue_rand(OP_START);
    issue_rand(OP_WRITE);
    issue_rand(OP_READ_ACK);
    for (int i = 0; i < n_bytes; i++) begin
      if (rd_dir) begin
        issue_rand(OP_READ);
        issue_rand(OP_SEND_ACK);
      end else begin
        issue_rand(OP_WRITE);
        issue_rand(OP_READ_ACK);
      end
    end
    // Now and then leave the bus held for a repeated start.
    if ($urandom_range(9) != 0) issue_rand(OP_STOP);
  endtask

  task automatic random_traffic(input int n);
    int target;
    target = cmds_sent + n;
    while (cmds_sent < target) begin
      if ($urandom_range(99) < 80)
        bus_transfer();
      else
        issue_rand(3'($urandom_range(7)));
    end
  endtask

  initial begin
    logic [31:0] rd;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_ticks();
    set_ticks(32'd1);
    // A register index past the end must leave phase_ticks alone.
    apb_xfer(1'b1, ADDR_SPARE, 32'hFFFF_FFFF, rd);
    check_ticks();

    issue_cmd(OP_START, 8'h00, 1'b0, 8'h00);
    issue_cmd(OP_WRITE, 8'h00, 1'b0, 8'h00);
    issue_cmd(OP_WRITE, 8'hFF, 1'b1, 8'hFF);
    issue_cmd(OP_READ_ACK, 8'h00, 1'b0, 8'h7F);
    issue_cmd(OP_READ_ACK, 8'hFF, 1'b1, 8'h80);
    issue_cmd(OP_READ, 8'h00, 1'b0, 8'h00);
    issue_cmd(OP_READ, 8'hFF, 1'b1, 8'hFF);
    issue_cmd(OP_READ, 8'h3C, 1'b0, 8'hA5);
    issue_cmd(OP_SEND_ACK, 8'hFF, 1'b0, 8'hFF);
    issue_cmd(OP_SEND_ACK, 8'h00, 1'b1, 8'h00);
    issue_cmd(OP_WRITE, 8'h5A, 1'b0, 8'h00);
    issue_cmd(OP_STOP, 8'hFF, 1'b1, 8'hFF);
    issue_cmd(OP_SPARE_LO, 8'hFF, 1'b1, 8'hFF);
    issue_cmd(OP_SPARE_HI, 8'h00, 1'b0, 8'h00);
    issue_cmd(OP_START, 8'hA5, 1'b1, 8'h5A);
    issue_cmd(OP_SEND_ACK, 8'h00, 1'b0, 8'h00);
    issue_cmd(OP_STOP, 8'h00, 1'b0, 8'h00);

    reconfigure(32'd2, 0, 0);
    random_traffic(15);
    reconfigure(32'hABCD_0001, 80, 0);
    random_traffic(8);
    wait_drain();
    random_traffic(8);
    reconfigure(32'd3, 0, 80);
    random_traffic(15);
    reconfigure(32'd7, 6, 6);
    random_traffic(15);

    // Slowest and out-of-range timing, with one short command each.
    reconfigure(32'h0000_FFFF, 0, 0);
    issue_rand(OP_READ_ACK);
    reconfigure(32'd0, 0, 0);
    issue_rand(OP_READ_ACK);

    wait_drain();
    repeat (64) @(posedge clk_i);
    if (sb.errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
